// ----- hdl/mtra_pkg.sv -----
// ----------------------------------------------------------------------------
// mtra_pkg
// Types and constants shared by the memory-type range allocator, its port
// checker and its bench.
// ----------------------------------------------------------------------------
package mtra_pkg;

  // Command codes of an input word.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_MAP   = 2'd1;
  localparam logic [1:0] CMD_UNMAP = 2'd2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd1;

  // Width of an entry count that can hold the largest table size.
  localparam int unsigned CNT_W = 5;

  // Bit positions in the marks of an entry, and in a mask register word.
  localparam int unsigned MK_VALID_B    = 8;
  localparam int unsigned MK_LOCKED_B   = 9;
  localparam int unsigned MK_FIRMWARE_B = 10;
  localparam int unsigned MASK_VALID_B  = 11;

  localparam logic [7:0]  TYPE_WC    = 8'd1;
  localparam logic [7:0]  TYPE_WB    = 8'd6;
  localparam logic [63:0] PAGE_LOW   = 64'h0000_0000_0000_0fff;
  localparam logic [15:0] REFCNT_MAX = 16'hffff;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  entry_index;
    logic [63:0] raw_base;
    logic [63:0] raw_mask;
    logic [35:0] req_start;
    logic [31:0] req_size;
    logic        lazy_write;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic        hw_write;
    logic [2:0]  write_index;
    logic [63:0] write_base;
    logic [63:0] write_mask;
  } out_word_t;

  // One entry of the range table as it is held in memory.
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] mask;
    logic [15:0] refcnt;
    logic [10:0] marks;
  } ent_t;

endpackage

// ----- hdl/mtra_ram.sv -----
// ----------------------------------------------------------------------------
// mtra_ram
// Simple dual-port RAM: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mtra_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/memory_type_range_allocator.sv -----
// ----------------------------------------------------------------------------
// memory_type_range_allocator
// Table of variable memory-type range entries with reference counts.
// ----------------------------------------------------------------------------
// Usage. Requests arrive as words on the in channel (valid/ready) and each
// one gives exactly one result word on the out channel (valid/ready). A load
// word seeds one entry from firmware base and mask register words; a map word
// finds an entry that already holds the range and counts it up, or programs
// the first free entry as write-combining; an unmap word counts an entry
// down, restoring the firmware type at one and freeing the entry at zero.
// The two configuration registers are written through a plain write port;
// the user writes them only while the block is idle; the block does not enforce it.
// Flow. The block works on one word at a time. A load word, or a word that
// fails its checks on acceptance, goes straight to the update state. A map
// or unmap word scans the usable entries through the single read port of
// the entry memory, one entry per cycle, and then writes the entry back;
// with no usable entry the scan reads nothing.
// The next word is accepted as soon as the previous result has gone into the
// output register, even while that result still waits to be taken.
// Reset clears the control state and marks every entry as never written, so
// it reads as a free, all-zero entry; no clearing pass is needed. When the
// receiver stalls, a finished result waits in the update state until the
// output register is free, and no further word is accepted meanwhile.
// ----------------------------------------------------------------------------
module memory_type_range_allocator #(
  parameter int unsigned MAX_ENTRIES = 8,
  parameter int unsigned ADDR_BITS   = 36
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mtra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtra_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mtra_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mtra_pkg::out_word_t           out_data
);

  import mtra_pkg::*;

  // Address width of the entry memory.
  localparam int unsigned AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  // Width that holds a start plus a size, and an entry base plus its length.
  localparam int unsigned CW    = ((ADDR_BITS > 36) ? ADDR_BITS : 36) + 1;
  localparam int unsigned ENT_W = $bits(ent_t);
  localparam logic [63:0] ADDR_FIELD = ((64'd1 << ADDR_BITS) - 64'd1) & ~PAGE_LOW;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state;

  // Configuration registers and the usable entry count derived from them.
  logic             feature_en;
  logic [3:0]       entry_count;
  logic [CNT_W-1:0] n_use;

  assign n_use = ({1'b0, entry_count} < CNT_W'(MAX_ENTRIES)) ?
                 {1'b0, entry_count} : CNT_W'(MAX_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_en  <= 1'b1;
      entry_count <= 4'd8;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FEATURE:     feature_en  <= cfg_data[0];
        REG_ENTRY_COUNT: entry_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // The word in hand, with its alignment check and range end worked out on
  // acceptance so that the scan only has to compare.
  logic [1:0]  it_cmd;
  logic [2:0]  it_idx;
  logic [63:0] it_base;
  logic [63:0] it_mask;
  logic [35:0] it_start;
  logic [31:0] it_sm1;
  logic [CW-1:0] it_end;
  logic        it_go;

  logic        acc;
  logic [31:0] acc_sm1;
  logic        acc_aligned;
  logic        acc_go;

  assign in_ready    = (state == ST_IDLE);
  assign acc         = in_valid && in_ready;
  assign acc_sm1     = in_data.req_size - 32'd1;
  assign acc_aligned = (in_data.req_start[11:0] == 12'd0) &&
                       ((in_data.req_start[31:0] & acc_sm1) == 32'd0);
  assign acc_go      = ((in_data.cmd == CMD_MAP) || (in_data.cmd == CMD_UNMAP)) &&
                       feature_en && in_data.lazy_write && acc_aligned;

  always_ff @(posedge clk) begin
    if (acc) begin
      it_cmd   <= in_data.cmd;
      it_idx   <= in_data.entry_index;
      it_base  <= in_data.raw_base;
      it_mask  <= in_data.raw_mask;
      it_start <= in_data.req_start;
      it_sm1   <= acc_sm1;
      it_end   <= CW'(in_data.req_start) + CW'(in_data.req_size);
      it_go    <= acc_go;
    end
  end

  // Entry memory. An entry that has never been written reads as all zero,
  // which is the reset state of every entry.
  logic [MAX_ENTRIES-1:0] entry_vld;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  ent_t                   ram_wrec;
  logic [AW-1:0]          ram_raddr;
  logic [ENT_W-1:0]       ram_rdata;

  mtra_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ENTRIES),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wrec),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Scan: one read issued per cycle, each entry checked as its data returns.
  logic [CNT_W-1:0] scan_idx;
  logic             iss;
  logic             chk_vld;
  logic [AW-1:0]    chk_idx;
  logic             rd_zero;
  ent_t             rd_rec;
  logic [CW-1:0]    e_b;
  logic [CW-1:0]    e_lm;
  logic [CW-1:0]    e_top;
  logic             e_hit;
  logic             e_free;

  assign iss       = (state == ST_SCAN) && (scan_idx < n_use);
  assign ram_raddr = scan_idx[AW-1:0];
  assign rd_rec    = rd_zero ? '0 : ent_t'(ram_rdata);

  // The entry spans [base, base + length), length being one more than the
  // address bits that the mask leaves free, page offset included.
  assign e_b    = CW'(rd_rec.base & ADDR_FIELD);
  assign e_lm   = CW'((~rd_rec.mask & ADDR_FIELD) | PAGE_LOW);
  assign e_top  = e_b + e_lm + CW'(1);
  assign e_hit  = rd_rec.marks[MK_VALID_B] && (CW'(it_start) >= e_b) && (it_end <= e_top);
  assign e_free = (rd_rec.marks == '0);

  logic          hit_found;
  logic [AW-1:0] hit_idx;
  ent_t          hit_rec;
  logic          free_found;
  logic [AW-1:0] free_idx;

  always_ff @(posedge clk) begin
    if (iss) begin
      rd_zero <= !entry_vld[scan_idx[AW-1:0]];
      chk_idx <= scan_idx[AW-1:0];
    end
    if (chk_vld && e_hit && !hit_found) begin
      hit_idx <= chk_idx;
      hit_rec <= rd_rec;
    end
    if (chk_vld && e_free && !free_found) begin
      free_idx <= chk_idx;
    end
  end

  // Update: the new entry value and the result word.
  out_word_t res;
  logic      upd_we;
  logic [AW-1:0] upd_addr;
  ent_t      upd_rec;
  logic      out_free;
  logic [15:0] dec_cnt;

  assign out_free = !out_valid || out_ready;
  assign dec_cnt  = (hit_rec.refcnt != 16'd0) ? (hit_rec.refcnt - 16'd1) : 16'd0;

  always_comb begin
    res      = '0;
    res.status = 1'b1;
    upd_we   = 1'b0;
    upd_addr = hit_idx;
    upd_rec  = hit_rec;
    case (it_cmd)
      CMD_LOAD: begin
        if ({2'b00, it_idx} < n_use) begin
          upd_we       = 1'b1;
          upd_addr     = AW'(it_idx);
          upd_rec.base = it_base;
          upd_rec.mask = it_mask;
          if (it_mask[MASK_VALID_B]) begin
            upd_rec.refcnt = 16'd1;
            upd_rec.marks  = {1'b1, (it_base[7:0] == TYPE_WB), 1'b1, it_base[7:0]};
          end else begin
            upd_rec.refcnt = 16'd0;
            upd_rec.marks  = '0;
          end
          res.status = 1'b0;
        end
      end
      CMD_MAP: begin
        if (it_go && hit_found) begin
          upd_we         = 1'b1;
          upd_rec.refcnt = (hit_rec.refcnt != REFCNT_MAX) ?
                           (hit_rec.refcnt + 16'd1) : REFCNT_MAX;
          res.status     = 1'b0;
        end else if (it_go && free_found) begin
          upd_we          = 1'b1;
          upd_addr        = free_idx;
          upd_rec.base    = (64'(it_start) & ADDR_FIELD) | 64'(TYPE_WC);
          upd_rec.mask    = (~{32'd0, it_sm1} & ADDR_FIELD) | (64'd1 << MASK_VALID_B);
          upd_rec.refcnt  = 16'd1;
          upd_rec.marks   = '0;
          upd_rec.marks[MK_VALID_B] = 1'b1;
          res.status      = 1'b0;
          res.hw_write    = 1'b1;
          res.write_index = 3'(free_idx);
          res.write_base  = upd_rec.base;
          res.write_mask  = upd_rec.mask;
        end
      end
      CMD_UNMAP: begin
        if (it_go && hit_found) begin
          upd_we         = 1'b1;
          upd_rec.refcnt = dec_cnt;
          if ((dec_cnt == 16'd1) && hit_rec.marks[MK_FIRMWARE_B]) begin
            // Back to a single firmware user: restore the firmware type.
            upd_rec.base = (hit_rec.base & ADDR_FIELD) | 64'(hit_rec.marks[7:0]);
          end else if (dec_cnt == 16'd0) begin
            upd_rec         = '0;
            res.hw_write    = 1'b1;
            res.write_index = 3'(hit_idx);
          end
          res.status = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign ram_we    = (state == ST_UPDATE) && out_free && upd_we;
  assign ram_waddr = upd_addr;
  assign ram_wrec  = upd_rec;

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_idx   <= '0;
      chk_vld    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      entry_vld  <= '0;
      out_valid  <= 1'b0;
    end else begin
      chk_vld <= iss;
      if (chk_vld && e_hit) begin
        hit_found <= 1'b1;
      end
      if (chk_vld && e_free) begin
        free_found <= 1'b1;
      end
      if (iss) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (ram_we) begin
        entry_vld[ram_waddr] <= 1'b1;
      end
      // The output register is loaded when the update finds it free, and is
      // emptied when its word is taken and nothing new replaces it.
      if ((state == ST_UPDATE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            scan_idx   <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= acc_go ? ST_SCAN : ST_UPDATE;
          end
        end
        ST_SCAN: begin
          if (!iss && !chk_vld) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_UPDATE) && out_free) begin
      out_data <= res;
    end
  end

endmodule

// ----- hdl/mtra_checker.sv -----
// ----------------------------------------------------------------------------
// mtra_checker
// Port-level checks on the memory-type range allocator, bound to the top.
// ----------------------------------------------------------------------------
module mtra_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input mtra_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input mtra_pkg::out_word_t out_data
);

  import mtra_pkg::*;

  // A waiting result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Only one word is in hand at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in hand");

  // Without a hardware write the entry fields are all zero.
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hw_write |->
      out_data.write_index == 3'd0 && out_data.write_base == 64'd0 &&
      out_data.write_mask == 64'd0)
    else $error("entry fields set without a hardware write");

  // A refused request never writes hardware.
  a_refused_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hw_write |-> !out_data.status)
    else $error("hardware write on a refused request");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind memory_type_range_allocator mtra_checker u_mtra_checker (.*);

// ----- test/memory_type_range_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// memory_type_range_allocator_tb
// Self-checking bench for the memory-type range allocator. Input words are
// sent through the in channel with random gaps. A predictor of the range
// table works out the result word of every accepted input word and queues
// it. Each result word taken from the out channel is compared field by field
// with the oldest queued result.
// ----------------------------------------------------------------------------
module memory_type_range_allocator_tb;
  import mtra_pkg::*;

  localparam int unsigned TABLE_SIZE   = 8;
  localparam logic [63:0] ADDR_FIELD   = 64'h0000_000f_ffff_f000;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam int unsigned POOL_SIZE    = 12;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned SETTLE_TIME  = 20;
  localparam int unsigned REPORT_LIMIT = 100;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;

  // The bench's own copy of the range table and of the two registers.
  logic [63:0] tbl_base  [TABLE_SIZE];
  logic [63:0] tbl_mask  [TABLE_SIZE];
  logic [15:0] tbl_refs  [TABLE_SIZE];
  logic [10:0] tbl_marks [TABLE_SIZE];
  logic        tbl_feature;
  logic [3:0]  tbl_count;

  // Result words still owed by the block, oldest first.
  out_word_t expected_results[$];

  // When set, neither side inserts gaps.
  bit quiet = 1'b0;
  // Asks the result side for one long stall.
  bit hold_request = 1'b0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  // A pool of aligned ranges, so that maps and unmaps keep meeting each other.
  logic [35:0] pool_start [POOL_SIZE];
  int unsigned pool_log   [POOL_SIZE];

  memory_type_range_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one input word to the table copy and returns the result word
  // that the block must give for it.
  function automatic out_word_t predict_allocation(in_word_t w);
    out_word_t   r;
    int          n;
    int          hit;
    int          spare;
    logic [63:0] start;
    logic [63:0] size;
    logic [63:0] sm1;
    logic [63:0] lo;
    logic [63:0] span;
    logic [10:0] m;
    r = '0;
    r.status = 1'b1;
    n = (tbl_count < TABLE_SIZE) ? int'(tbl_count) : TABLE_SIZE;
    start = {28'd0, w.req_start};
    size = {32'd0, w.req_size};
    // The size mask wraps at 32 bits, so a zero size demands a 4 GiB aligned start.
    sm1 = {32'd0, w.req_size - 32'd1};
    if (w.cmd == CMD_LOAD) begin
      if (int'(w.entry_index) < n) begin
        tbl_base[w.entry_index] = w.raw_base;
        tbl_mask[w.entry_index] = w.raw_mask;
        if (w.raw_mask[MASK_VALID_B]) begin
          m = '0;
          m[7:0] = w.raw_base[7:0];
          m[MK_VALID_B] = 1'b1;
          m[MK_FIRMWARE_B] = 1'b1;
          m[MK_LOCKED_B] = (w.raw_base[7:0] == TYPE_WB);
          tbl_marks[w.entry_index] = m;
          tbl_refs[w.entry_index] = 16'd1;
        end else begin
          tbl_marks[w.entry_index] = '0;
          tbl_refs[w.entry_index] = '0;
        end
        r.status = 1'b0;
      end
    end else if ((w.cmd == CMD_MAP || w.cmd == CMD_UNMAP) && tbl_feature && w.lazy_write) begin
      if ((start & PAGE_LOW) == 64'd0 && (start & sm1) == 64'd0) begin
        // The first valid entry that holds the whole range wins.
        hit = -1;
        for (int i = 0; i < n; i++) begin
          if (hit < 0 && tbl_marks[i][MK_VALID_B]) begin
            lo = tbl_base[i] & ADDR_FIELD;
            span = 64'd1 + ((~tbl_mask[i] & ADDR_FIELD) | PAGE_LOW);
            if (start >= lo && start + size <= lo + span) hit = i;
          end
        end
        if (w.cmd == CMD_MAP) begin
          if (hit >= 0) begin
            if (tbl_refs[hit] != REFCNT_MAX) tbl_refs[hit] = tbl_refs[hit] + 16'd1;
            r.status = 1'b0;
          end else begin
            spare = -1;
            for (int i = 0; i < n; i++) begin
              if (spare < 0 && tbl_marks[i] == '0) spare = i;
            end
            if (spare >= 0) begin
              tbl_refs[spare] = 16'd1;
              tbl_base[spare] = (start & ADDR_FIELD) | {56'd0, TYPE_WC};
              tbl_mask[spare] = (~sm1 & ADDR_FIELD) | (64'd1 << MASK_VALID_B);
              tbl_marks[spare] = 11'd1 << MK_VALID_B;
              r.hw_write = 1'b1;
              r.write_index = spare[2:0];
              r.write_base = tbl_base[spare];
              r.write_mask = tbl_mask[spare];
              r.status = 1'b0;
            end
          end
        end else if (hit >= 0) begin
          if (tbl_refs[hit] != 16'd0) tbl_refs[hit] = tbl_refs[hit] - 16'd1;
          if (tbl_refs[hit] == 16'd1 && tbl_marks[hit][MK_FIRMWARE_B]) begin
            // Back to the firmware type; the hardware is left alone.
            tbl_base[hit] = (tbl_base[hit] & ADDR_FIELD) | {56'd0, tbl_marks[hit][7:0]};
          end else if (tbl_refs[hit] == 16'd0) begin
            tbl_base[hit] = '0;
            tbl_mask[hit] = '0;
            tbl_marks[hit] = '0;
            r.hw_write = 1'b1;
            r.write_index = hit[2:0];
          end
          r.status = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic in_word_t make_word(logic [1:0] cmd, logic [2:0] idx, logic [63:0] base,
                                         logic [63:0] mask, logic [35:0] start,
                                         logic [31:0] size, logic lazy);
    in_word_t w;
    w.cmd = cmd;
    w.entry_index = idx;
    w.raw_base = base;
    w.raw_mask = mask;
    w.req_start = start;
    w.req_size = size;
    w.lazy_write = lazy;
    return w;
  endfunction

  // Two large ranges anywhere in the address space, the rest packed into one
  // 16 MiB window so that they overlap and nest.
  function automatic void build_pool();
    logic [63:0] r64;
    logic [35:0] region;
    r64 = {$urandom, $urandom};
    region = {r64[47:36], 24'd0};
    for (int i = 0; i < POOL_SIZE; i++) begin
      r64 = {$urandom, $urandom};
      if (i < 2) begin
        pool_log[i] = $urandom_range(24, 31);
        pool_start[i] = r64[35:0] & ~((36'd1 << pool_log[i]) - 36'd1);
      end else begin
        pool_log[i] = $urandom_range(12, 20);
        pool_start[i] = region + ({12'd0, r64[23:0]} & ~((36'd1 << pool_log[i]) - 36'd1));
      end
    end
  endfunction

  // Mostly well-formed maps, unmaps and firmware loads on the pool; the rest
  // is noise with every field random.
  function automatic in_word_t random_word();
    in_word_t    w;
    logic [63:0] r64;
    logic [35:0] span_mask;
    int unsigned pick;
    int unsigned p;
    int unsigned lg;
    int unsigned sub;
    r64 = {$urandom, $urandom};
    w.cmd = 2'($urandom_range(0, 3));
    w.entry_index = 3'($urandom_range(0, 7));
    w.raw_base = {$urandom, $urandom};
    w.raw_mask = {$urandom, $urandom};
    w.req_start = r64[35:0];
    w.req_size = $urandom;
    w.lazy_write = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    p = $urandom_range(0, POOL_SIZE - 1);
    lg = pool_log[p];
    if (pick < 75) begin
      w.req_start = pool_start[p];
      if (lg > 12 && $urandom_range(0, 3) == 0) begin
        // An aligned piece of the pooled range, which should hit its entry.
        sub = $urandom_range(12, lg - 1);
        span_mask = (36'd1 << lg) - 36'd1;
        w.req_start = pool_start[p] + (r64[35:0] & span_mask & ~((36'd1 << sub) - 36'd1));
        lg = sub;
      end
      w.req_size = 32'd1 << lg;
      w.cmd = (pick < 40) ? CMD_MAP : CMD_UNMAP;
      w.lazy_write = ($urandom_range(0, 19) != 0);
    end else if (pick < 87) begin
      w.cmd = CMD_LOAD;
      w.raw_base[35:12] = pool_start[p][35:12];
      case ($urandom_range(0, 3))
        0: w.raw_base[7:0] = TYPE_WB;
        1: w.raw_base[7:0] = TYPE_WC;
        2: w.raw_base[7:0] = 8'd0;
        default: ;
      endcase
      span_mask = ~((36'd1 << lg) - 36'd1);
      w.raw_mask[35:12] = span_mask[35:12];
      w.raw_mask[MASK_VALID_B] = ($urandom_range(0, 4) != 0);
    end
    return w;
  endfunction

  // Offers one word, holding valid high until it is taken, then queues the
  // predicted result. Valid is only lowered when a gap is drawn, so a word
  // that follows straight on keeps valid high without a glitch.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_results.push_back(predict_allocation(w));
  endtask

  // Waits until every owed result word has arrived and the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (SETTLE_TIME) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_FEATURE:     tbl_feature = data[0];
      REG_ENTRY_COUNT: tbl_count = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
    error_count++;
    if (error_count <= REPORT_LIMIT)
      $error("%s mismatch: expected %h, got %h", name, want, got);
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (expected_results.size() == 0) begin
      error_count++;
      if (error_count <= REPORT_LIMIT) $error("result word arrived with none expected");
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status)
      report_mismatch("status", 64'(want.status), 64'(got.status));
    if (got.hw_write !== want.hw_write)
      report_mismatch("hw_write", 64'(want.hw_write), 64'(got.hw_write));
    if (got.write_index !== want.write_index)
      report_mismatch("write_index", 64'(want.write_index), 64'(got.write_index));
    if (got.write_base !== want.write_base)
      report_mismatch("write_base", want.write_base, got.write_base);
    if (got.write_mask !== want.write_mask)
      report_mismatch("write_mask", want.write_mask, got.write_mask);
  endtask

  // Firmware seeding: a locked write-back entry, an uncached one, a word
  // without the mask valid bit, all ones and the unused command code.
  task automatic test_loads();
    send_word(make_word(CMD_LOAD, 3'd0, 64'h0000_0001_0000_0006, 64'hffff_ffff_fff0_0800,
                        '0, '0, 1'b0));
    send_word(make_word(CMD_LOAD, 3'd1, 64'h0000_0000_c000_0000, 64'h0000_000f_f000_0800,
                        '0, '0, 1'b1));
    send_word(make_word(CMD_LOAD, 3'd2, '1, 64'hffff_ffff_ffff_f7ff, '1, '1, 1'b1));
    send_word(make_word(CMD_LOAD, 3'd7, '1, '1, '1, '1, 1'b1));
    send_word(make_word(CMD_LOAD, 3'd7, '0, '0, '0, '0, 1'b0));
    send_word(make_word(CMD_UNUSED, 3'd5, '1, '1, 36'h0_2000_0000, 32'h0000_1000, 1'b1));
  endtask

  // Alignment checks, a fresh entry counted up and down until it is freed,
  // the firmware type restored at one, a zero size and the address extremes.
  task automatic test_map_unmap();
    send_word(make_word(CMD_MAP, '0, '0, '0, 36'h0_2000_0000, 32'h0010_0000, 1'b0));
    send_word(make_word(CMD_MAP, '0, '0, '0, 36'h0_2000_0800, 32'h0000_1000, 1'b1));
    send_word(make_word(CMD_MAP, '0, '0, '0, 36'h0_2000_1000, 32'h0000_2000, 1'b1));
    send_word(make_word(CMD_MAP, '0, '0, '0, 36'h0_2000_0000, 32'h0010_0000, 1'b1));
    send_word(make_word(CMD_MAP, '0, '0, '0, 36'h0_2000_0000, 32'h0010_0000, 1'b1));
    send_word(make_word(CMD_MAP, '0, '0, '0, 36'h0_2000_1000, 32'h0000_1000, 1'b1));
    repeat (3) send_word(make_word(CMD_UNMAP, '0, '0, '0, 36'h0_2000_0000, 32'h0010_0000, 1'b1));
    send_word(make_word(CMD_UNMAP, '0, '0, '0, 36'h0_2000_0000, 32'h0010_0000, 1'b1));
    send_word(make_word(CMD_MAP, '0, '0, '0, 36'h1_0000_0000, 32'h0000_0000, 1'b1));
    send_word(make_word(CMD_UNMAP, '0, '0, '0, 36'h1_0000_0000, 32'h0000_1000, 1'b1));
    send_word(make_word(CMD_MAP, '1, '1, '1, '1, '1, 1'b1));
    send_word(make_word(CMD_MAP, '0, '0, '0, 36'hf_0000_0000, 32'h8000_0000, 1'b1));
    send_word(make_word(CMD_UNMAP, '0, '0, '0, 36'hf_0000_0000, 32'h8000_0000, 1'b1));
  endtask

  // Feature switched off, no usable entries, a table of three that fills up
  // and an entry count above the table size.
  task automatic test_config();
    set_register(REG_FEATURE, 4'd0);
    send_word(make_word(CMD_MAP, '0, '0, '0, 36'h0_3000_0000, 32'h0000_1000, 1'b1));
    send_word(make_word(CMD_UNMAP, '0, '0, '0, 36'h0_3000_0000, 32'h0000_1000, 1'b1));
    send_word(make_word(CMD_LOAD, 3'd3, 64'h0000_0000_3000_0000, '0, '0, '0, 1'b1));
    set_register(REG_FEATURE, 4'd1);
    set_register(REG_ENTRY_COUNT, 4'd0);
    send_word(make_word(CMD_LOAD, 3'd0, 64'h0000_0000_3000_0001, 64'h0000_000f_ffff_f800,
                        '0, '0, 1'b1));
    send_word(make_word(CMD_MAP, '0, '0, '0, 36'h0_3000_0000, 32'h0000_1000, 1'b1));
    set_register(REG_ENTRY_COUNT, 4'd3);
    for (int i = 5; i < 8; i++)
      send_word(make_word(CMD_MAP, '0, '0, '0, {4'd0, i[3:0], 28'd0}, 32'h0000_1000, 1'b1));
    send_word(make_word(CMD_LOAD, 3'd3, 64'h0000_0000_3000_0001, 64'h0000_000f_ffff_f800,
                        '0, '0, 1'b1));
    for (int i = 5; i < 8; i++)
      send_word(make_word(CMD_UNMAP, '0, '0, '0, {4'd0, i[3:0], 28'd0}, 32'h0000_1000, 1'b1));
    set_register(REG_ENTRY_COUNT, 4'd15);
    send_word(make_word(CMD_LOAD, 3'd7, 64'h0000_0000_3000_0001, 64'h0000_000f_ffff_f800,
                        '0, '0, 1'b1));
    send_word(make_word(CMD_LOAD, 3'd7, '0, '0, '0, '0, 1'b1));
  endtask

  // A single firmware entry is counted up many times back to back, then
  // counted down through the firmware restore at one, freed at zero and
  // missed once more. One usable entry keeps each scan short.
  task automatic test_refcount();
    set_register(REG_ENTRY_COUNT, 4'd1);
    send_word(make_word(CMD_LOAD, 3'd0, 64'h0000_0004_0000_0005, 64'h0000_000f_ffff_f800,
                        '0, '0, 1'b1));
    quiet = 1'b1;
    repeat (20)
      send_word(make_word(CMD_MAP, '0, '0, '0, 36'h4_0000_0000, 32'h0000_1000, 1'b1));
    repeat (22)
      send_word(make_word(CMD_UNMAP, '0, '0, '0, 36'h4_0000_0000, 32'h0000_1000, 1'b1));
    send_word(make_word(CMD_LOAD, 3'd0, '0, '0, '0, '0, 1'b1));
    quiet = 1'b0;
  endtask

  // The result side stops for a long stretch while words keep coming, so the
  // block fills up and holds its input off.
  task automatic test_backpressure();
    set_register(REG_ENTRY_COUNT, 4'd8);
    build_pool();
    hold_request = 1'b1;
    quiet = 1'b1;
    repeat (30) send_word(random_word());
    quiet = 1'b0;
  endtask

  task automatic test_random(input logic feature, input logic [3:0] count,
                             input int unsigned items);
    set_register(REG_FEATURE, {3'd0, feature});
    set_register(REG_ENTRY_COUNT, count);
    build_pool();
    for (int unsigned i = 0; i < items; i++) begin
      // Now and then a stretch of back-to-back words on both sides.
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_word(random_word());
    end
    quiet = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tbl_base[i] = '0;
      tbl_mask[i] = '0;
      tbl_refs[i] = '0;
      tbl_marks[i] = '0;
    end
    tbl_feature = 1'b1;
    tbl_count = 4'd8;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_loads();
    test_map_unmap();
    test_config();
    test_refcount();
    test_backpressure();
    test_random(1'b1, 4'd8, 425);
    test_random(1'b1, 4'd15, 425);
    test_random(1'b1, 4'd2, 350);
    test_random(1'b0, 4'd8, 150);
    test_random(1'b1, 4'd0, 150);
    test_random(1'b1, 4'd8, 500);
    drain();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: a random stall before each word, and one long stall when
  // asked for. Ready is only lowered when a stall is drawn.
  initial begin : result_sink
    int unsigned gap;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result(out_data);
  end

  // Ends the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
